// ===== design/lbhp_pkg.sv =====
// Shared types, constants and the pixel weight function for the lane base histogram.
`timescale 1ns / 1ps

package lbhp_pkg;

  localparam int VALUE_W  = 8;
  localparam int COORD_W  = 9;
  localparam int PEAK_W   = 9;
  localparam int SUM_W    = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Narrowest image width the split logic supports.
  localparam int MIN_WIDTH = 4;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_FIRST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_COUNT  = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [9:0] RST_IMAGE_WIDTH = 10'd320;
  localparam logic [8:0] RST_BAND_FIRST  = 9'd160;
  localparam logic [9:0] RST_BAND_COUNT  = 10'd79;

  typedef struct packed {
    logic [VALUE_W-1:0] pixel_value;
    logic [COORD_W-1:0] pixel_column;
    logic [COORD_W-1:0] pixel_row;
    logic               frame_end;
  } pixel_t;

  typedef struct packed {
    logic [PEAK_W-1:0] left_peak_column;
    logic [PEAK_W-1:0] right_peak_column;
  } peaks_t;

  // round(255 / v), ties to even; 0 for v == 0.
  function automatic logic [VALUE_W-1:0] weight_of(input logic [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] w;
    if (v >= 8'd171)      w = 8'd1;
    else if (v >= 8'd102) w = 8'd2;
    else if (v >= 8'd73)  w = 8'd3;
    else if (v >= 8'd57)  w = 8'd4;
    else if (v >= 8'd47)  w = 8'd5;
    else if (v >= 8'd40)  w = 8'd6;
    else if (v >= 8'd35)  w = 8'd7;
    else if (v >= 8'd30)  w = 8'd8;
    else if (v >= 8'd27)  w = 8'd9;
    else if (v >= 8'd25)  w = 8'd10;
    else if (v >= 8'd23)  w = 8'd11;
    else if (v >= 8'd21)  w = 8'd12;
    else if (v >= 8'd19)  w = 8'd13;
    else begin
      case (v)
        8'd18:   w = 8'd14;
        8'd17:   w = 8'd15;
        8'd16:   w = 8'd16;
        8'd15:   w = 8'd17;
        8'd14:   w = 8'd18;
        8'd13:   w = 8'd20;
        8'd12:   w = 8'd21;
        8'd11:   w = 8'd23;
        8'd10:   w = 8'd26;
        8'd9:    w = 8'd28;
        8'd8:    w = 8'd32;
        8'd7:    w = 8'd36;
        8'd6:    w = 8'd42;
        8'd5:    w = 8'd51;
        8'd4:    w = 8'd64;
        8'd3:    w = 8'd85;
        8'd2:    w = 8'd128;
        8'd1:    w = 8'd255;
        default: w = 8'd0;
      endcase
    end
    return w;
  endfunction

endpackage

// ===== design/lbhp_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
`timescale 1ns / 1ps

module lbhp_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read-during-write returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/lbhp_accum.sv =====
// Pixel path: band check, weight lookup and read-modify-write of the column sums.
`timescale 1ns / 1ps

module lbhp_accum
  import lbhp_pkg::*;
#(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_take,
  input  pixel_t                           in_word,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]   eff_w,
  input  logic [8:0]                       band_first,
  input  logic [9:0]                       band_count,
  output logic                             rd_en,
  output logic [$clog2(MAX_WIDTH)-1:0]     rd_addr,
  input  logic [SUM_W-1:0]                 rd_data,
  output logic                             wr_en,
  output logic [$clog2(MAX_WIDTH)-1:0]     wr_addr,
  output logic [SUM_W-1:0]                 wr_data,
  output logic                             fe_pend
);

  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int W_W    = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W  = (W_W > CFG_DATA_W) ? W_W : CFG_DATA_W;
  localparam int HW     = $clog2(MAX_HEIGHT + 1);
  localparam int RW     = (HW > 11) ? HW : 11;

  logic [CMP_W-1:0] col_ext;
  logic [RW-1:0]    row_ext, first_ext, end_ext;
  logic             hit;

  logic               s1_vld_r, s1_hit_r, s1_fe_r;
  logic [ADDR_W-1:0]  s1_addr_r;
  logic [VALUE_W-1:0] s1_wt_r;
  logic               fw_vld_r;
  logic [ADDR_W-1:0]  fw_addr_r;
  logic [SUM_W-1:0]   fw_data_r;

  logic [SUM_W-1:0] base;
  logic [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0] sum_sat;

  always_comb begin
    col_ext   = CMP_W'(in_word.pixel_column);
    row_ext   = RW'(in_word.pixel_row);
    first_ext = RW'(band_first);
    end_ext   = first_ext + RW'(band_count);
    hit = (col_ext < CMP_W'(eff_w)) && (row_ext < RW'(MAX_HEIGHT)) &&
          (row_ext >= first_ext) && (row_ext < end_ext);
  end

  assign rd_en   = in_take && hit;
  assign rd_addr = col_ext[ADDR_W-1:0];

  // the word written at the edge of our read is not in rd_data yet
  always_comb begin
    base     = (fw_vld_r && (fw_addr_r == s1_addr_r)) ? fw_data_r : rd_data;
    sum_wide = {1'b0, base} + (SUM_W+1)'(s1_wt_r);
    sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
  end

  assign wr_en   = s1_vld_r && s1_hit_r;
  assign wr_addr = s1_addr_r;
  assign wr_data = sum_sat;
  assign fe_pend = s1_vld_r && s1_fe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      fw_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_take;
      fw_vld_r <= wr_en;
    end
    s1_hit_r  <= hit;
    s1_fe_r   <= in_word.frame_end;
    s1_addr_r <= col_ext[ADDR_W-1:0];
    s1_wt_r   <= weight_of(in_word.pixel_value);
    fw_addr_r <= s1_addr_r;
    fw_data_r <= sum_sat;
  end

endmodule

// ===== design/lbhp_scan.sv =====
// Sweep sequencer: peak search per half and clearing of the column sums.
`timescale 1ns / 1ps

module lbhp_scan
  import lbhp_pkg::*;
#(
  parameter int MAX_WIDTH = 512
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [$clog2(MAX_WIDTH+1)-1:0] eff_w,
  output logic                           rd_en,
  output logic [$clog2(MAX_WIDTH)-1:0]   rd_addr,
  input  logic [SUM_W-1:0]               rd_data,
  output logic                           wr_en,
  output logic [$clog2(MAX_WIDTH)-1:0]   wr_addr,
  output logic [SUM_W-1:0]               wr_data,
  output logic                           busy,
  output logic                           out_valid,
  input  logic                           out_ready,
  output peaks_t                         out_data
);

  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int W_W    = $clog2(MAX_WIDTH + 1);
  localparam int PK_W   = (ADDR_W > PEAK_W) ? ADDR_W : PEAK_W;
  localparam logic [ADDR_W-1:0] LAST = ADDR_W'(MAX_WIDTH - 1);

  typedef enum logic [1:0] {SC_IDLE, SC_RUN, SC_DRAIN, SC_OUT} sc_state_t;

  sc_state_t         state_r;
  logic [ADDR_W-1:0] cnt_r;
  logic              emit_r;
  logic              d_vld_r;
  logic [ADDR_W-1:0] d_addr_r;
  logic [ADDR_W-1:0] best_l_r, best_r_r;
  logic [SUM_W-1:0]  max_l_r, max_r_r;
  logic              out_valid_r;
  peaks_t            out_data_r;

  logic [W_W-1:0]  half, d_ext;
  logic            take_l, take_r;
  logic [PK_W-1:0] pk_l, pk_r;

  always_comb begin
    half   = eff_w >> 1;
    d_ext  = W_W'(d_addr_r);
    take_l = d_vld_r && (d_ext < half) &&
             ((d_addr_r == '0) || (rd_data > max_l_r));
    take_r = d_vld_r && (d_ext > half) && (d_ext < eff_w) &&
             ((d_ext == half + W_W'(1)) || (rd_data > max_r_r));
    pk_l   = PK_W'(best_l_r);
    pk_r   = PK_W'(best_r_r);
  end

  assign rd_en     = (state_r == SC_RUN);
  assign rd_addr   = cnt_r;
  assign wr_en     = d_vld_r;
  assign wr_addr   = d_addr_r;
  assign wr_data   = '0;
  assign busy      = (state_r != SC_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // reset runs a silent sweep that zeroes the whole memory
      state_r     <= SC_RUN;
      cnt_r       <= '0;
      emit_r      <= 1'b0;
      d_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      d_vld_r <= (state_r == SC_RUN);
      // in SC_OUT the load below decides valid
      if (out_valid_r && out_ready && (state_r != SC_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        SC_IDLE: begin
          if (start) begin
            state_r <= SC_RUN;
            cnt_r   <= '0;
            emit_r  <= 1'b1;
          end
        end
        SC_RUN: begin
          cnt_r <= cnt_r + ADDR_W'(1);
          if (cnt_r == LAST) begin
            state_r <= SC_DRAIN;
          end
        end
        SC_DRAIN: begin
          state_r <= emit_r ? SC_OUT : SC_IDLE;
        end
        SC_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r                  <= 1'b1;
            out_data_r.left_peak_column  <= pk_l[PEAK_W-1:0];
            out_data_r.right_peak_column <= pk_r[PEAK_W-1:0];
            state_r                      <= SC_IDLE;
          end
        end
        default: begin
          state_r <= SC_IDLE;
        end
      endcase
    end
    d_addr_r <= cnt_r;
    if (take_l) begin
      best_l_r <= d_addr_r;
      max_l_r  <= rd_data;
    end
    if (take_r) begin
      best_r_r <= d_addr_r;
      max_r_r  <= rd_data;
    end
  end

endmodule

// ===== design/lane_base_histogram_peaks.sv =====
// Top level: column histogram over a row band with per-half peak search at frame end.
`timescale 1ns / 1ps
// Throughput: one pixel word per cycle while in_ready is high; the column sum is read
//   when the word is taken, written back the next cycle, with write-to-read forwarding.
// Frame end: the sweep reads and clears every column, then loads the result word once
//   the previous result has gone; in_ready stays low until the result is loaded.
// Reset: synchronous, active low; afterwards a clearing sweep zeroes the memory,
//   in_ready stays low meanwhile, config is always taken.

module lane_base_histogram_peaks
  import lbhp_pkg::*;
#(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pixel_t                in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output peaks_t                out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int W_W    = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W  = (W_W > CFG_DATA_W) ? W_W : CFG_DATA_W;

  // configuration registers
  logic [9:0] image_width_r;
  logic [8:0] band_first_r;
  logic [9:0] band_count_r;

  logic [CMP_W-1:0] iw_ext, eff_c;
  logic [W_W-1:0]   eff_w;

  logic in_take;
  logic fe_pend;
  logic sc_busy;

  // memory port requests from both users
  logic              ac_re, ac_we, sc_re, sc_we;
  logic [ADDR_W-1:0] ac_raddr, ac_waddr, sc_raddr, sc_waddr;
  logic [SUM_W-1:0]  ac_wdata, sc_wdata;
  logic              ram_re, ram_we;
  logic [ADDR_W-1:0] ram_raddr, ram_waddr;
  logic [SUM_W-1:0]  ram_wdata, ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r <= RST_IMAGE_WIDTH;
      band_first_r  <= RST_BAND_FIRST;
      band_count_r  <= RST_BAND_COUNT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH: image_width_r <= cfg_data;
        CFG_BAND_FIRST:  band_first_r  <= cfg_data[8:0];
        CFG_BAND_COUNT:  band_count_r  <= cfg_data;
        default: ;  // unknown index, dropped
      endcase
    end
  end

  // effective width, clamped between MIN_WIDTH and what the memory holds
  always_comb begin
    iw_ext = CMP_W'(image_width_r);
    if (iw_ext < CMP_W'(MIN_WIDTH)) begin
      eff_c = CMP_W'(MIN_WIDTH);
    end else if (iw_ext > CMP_W'(MAX_WIDTH)) begin
      eff_c = CMP_W'(MAX_WIDTH);
    end else begin
      eff_c = iw_ext;
    end
    eff_w = eff_c[W_W-1:0];
  end

  // Stall input while a frame-end word finishes its update and during the sweep.
  assign in_ready = !sc_busy && !fe_pend;
  assign in_take  = in_valid && in_ready;

  lbhp_accum #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_take    (in_take),
    .in_word    (in_data),
    .eff_w      (eff_w),
    .band_first (band_first_r),
    .band_count (band_count_r),
    .rd_en      (ac_re),
    .rd_addr    (ac_raddr),
    .rd_data    (ram_rdata),
    .wr_en      (ac_we),
    .wr_addr    (ac_waddr),
    .wr_data    (ac_wdata),
    .fe_pend    (fe_pend)
  );

  // The sweep starts the cycle the frame-end update writes, so its first read
  // lands after that write.
  lbhp_scan #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (fe_pend),
    .eff_w     (eff_w),
    .rd_en     (sc_re),
    .rd_addr   (sc_raddr),
    .rd_data   (ram_rdata),
    .wr_en     (sc_we),
    .wr_addr   (sc_waddr),
    .wr_data   (sc_wdata),
    .busy      (sc_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // the two users never access the memory in the same cycle
  assign ram_re    = sc_busy ? sc_re    : ac_re;
  assign ram_raddr = sc_busy ? sc_raddr : ac_raddr;
  assign ram_we    = sc_busy ? sc_we    : ac_we;
  assign ram_waddr = sc_busy ? sc_waddr : ac_waddr;
  assign ram_wdata = sc_busy ? sc_wdata : ac_wdata;

  lbhp_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_WIDTH)
  ) u_sums (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ===== design/lbhp_checker.sv =====
// Port-level checker for the lane base histogram, bound to the top level.
`timescale 1ns / 1ps

module lbhp_checker
  import lbhp_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input pixel_t                in_data,
  input logic                  out_valid,
  input logic                  out_ready,
  input peaks_t                out_data
);

  // reset always starts the clearing sweep
  a_reset_sweep: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input ready right after reset");

  a_fe_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.frame_end |=> !in_ready)
    else $error("input taken right after a frame-end word");

  a_result_after_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result word without a sweep");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word dropped or changed while stalled");

endmodule

bind lane_base_histogram_peaks lbhp_checker u_lbhp_checker (.*);

// ===== sim/tb.sv =====
// Self-checking bench for the lane base histogram: pixel stream in, peak columns out.
`timescale 1ns / 1ps

module tb;
  import lbhp_pkg::*;

  localparam int COLS = 512;
  localparam int ROWS = 512;
  // Long enough for a frame-end sweep over all COLS columns, with some slack on top.
  localparam int SETTLE_CYCLES = COLS + 16;
  localparam int LIMIT = 3000000;
  localparam int RANDOM_WORDS = 600;
  localparam int MIN_FRAMES_PER_MODE = 15;
  // Index past the three registers; the block must ignore writes to it.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  pixel_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  peaks_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  always #1 clk = ~clk;

  lane_base_histogram_peaks #(
    .MAX_WIDTH (COLS),
    .MAX_HEIGHT(ROWS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Bench state
  // ---------------------------------------------------------------------------
  pixel_t pixels_todo[$];      // pixel words waiting for the driver
  peaks_t peaks_due[$];        // predicted peak words, oldest first
  peaks_t peaks_want;

  int tx_idle_pct = 26;        // percent of cycles the pixel source holds off
  int rx_idle_pct = 55;        // percent of cycles the peak sink stalls
  int cycle_count = 0;
  int mismatch_count = 0;
  int pixels_sent = 0;         // accepted pixel words
  int peaks_checked = 0;       // peak words compared
  int shaped_words = 0;        // well-formed pixel words queued by the frame builder

  // Predictor copy of the histogram and the registers.
  logic [SUM_W-1:0] col_sum[COLS];
  logic [CFG_DATA_W-1:0] img_width_reg = RST_IMAGE_WIDTH;
  logic [COORD_W-1:0] band_first_reg = RST_BAND_FIRST;
  logic [CFG_DATA_W-1:0] band_count_reg = RST_BAND_COUNT;

  initial begin
    foreach (col_sum[i]) col_sum[i] = '0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // 255 / v rounded to nearest, ties to even; zero pixels weigh nothing.
  function automatic int unsigned pixel_weight(input int unsigned v);
    int unsigned q, r;
    if (v == 0) return 0;
    q = 255 / v;
    r = 255 % v;
    if (2 * r > v || (2 * r == v && q[0])) q++;
    return (q > 255) ? 255 : q;
  endfunction

  function automatic int unsigned active_width();
    int unsigned w;
    w = img_width_reg;
    if (w < MIN_WIDTH) w = MIN_WIDTH;
    if (w > COLS) w = COLS;
    return w;
  endfunction

  // Adds one accepted pixel to the column sums; on frame end the pixel is
  // counted first, then both halves are scanned and the sums are cleared.
  task automatic absorb_pixel(input pixel_t p);
    int unsigned w, half, col, row, s, lo, hi;
    peaks_t pk;
    w = active_width();
    half = w / 2;
    col = p.pixel_column;
    row = p.pixel_row;
    // band end taken without wrap: first + count may run past the last row
    if (col < w && row < ROWS && row >= band_first_reg &&
        row < int'(band_first_reg) + int'(band_count_reg)) begin
      s = col_sum[col] + pixel_weight(p.pixel_value);
      col_sum[col] = (s > SUM_MAX) ? SUM_MAX : SUM_W'(s);
    end
    if (p.frame_end) begin
      // strict compare keeps the lowest column among equal maxima
      lo = 0;
      for (int unsigned c = 1; c < half; c++)
        if (col_sum[c] > col_sum[lo]) lo = c;
      // the middle column W/2 belongs to neither half
      hi = half + 1;
      for (int unsigned c = half + 2; c < w; c++)
        if (col_sum[c] > col_sum[hi]) hi = c;
      pk.left_peak_column = PEAK_W'(lo);
      pk.right_peak_column = PEAK_W'(hi);
      peaks_due = {peaks_due, pk};
      foreach (col_sum[i]) col_sum[i] = '0;
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Pixel driver: one word per handshake, random hold-off between words.
  // The word is predicted on the edge at which it is accepted.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        absorb_pixel(in_data);
        pixels_sent++;
      end
      // valid only drops or moves on once the current word is gone
      if (!in_valid || in_ready) begin
        if (pixels_todo.size() != 0 &&
            (tx_idle_pct == 0 || $urandom_range(0, 99) >= tx_idle_pct)) begin
          in_data <= pixels_todo.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Peak monitor: compare each accepted word with the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (peaks_due.size() == 0) begin
        report_mismatch($sformatf("peak word with no frame end pending (left %0d right %0d)",
                                  out_data.left_peak_column, out_data.right_peak_column));
      end else begin
        peaks_want = peaks_due.pop_front();
        if (out_data.left_peak_column !== peaks_want.left_peak_column)
          report_mismatch($sformatf("left peak got %0d want %0d",
                                    out_data.left_peak_column, peaks_want.left_peak_column));
        if (out_data.right_peak_column !== peaks_want.right_peak_column)
          report_mismatch($sformatf("right peak got %0d want %0d",
                                    out_data.right_peak_column, peaks_want.right_peak_column));
        peaks_checked++;
      end
    end
    out_ready <= (rx_idle_pct == 0) || ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Watchdog over the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("timeout after %0d cycles, %0d peak words still due",
               cycle_count, peaks_due.size());
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Register write; called right after a rising edge. Valid is left high so
  // back-to-back writes never lower and raise it in one step.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] d);
    cfg_index <= idx;
    cfg_data <= d;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_IMAGE_WIDTH: img_width_reg = d;
      CFG_BAND_FIRST:  band_first_reg = d[COORD_W-1:0];
      CFG_BAND_COUNT:  band_count_reg = d;
      default: ;
    endcase
  endtask

  task automatic program_band(input int w, input int first, input int count);
    cfg_write(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
    cfg_write(CFG_BAND_FIRST, CFG_DATA_W'(first));
    cfg_write(CFG_BAND_COUNT, CFG_DATA_W'(count));
    cfg_valid <= 1'b0;
  endtask

  // Wait until every queued word went in and every peak word came out, then
  // give the sweep time to finish before anything touches the registers.
  task automatic settle();
    while (pixels_todo.size() != 0 || in_valid || peaks_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_pixel(input int v, input int c, input int r, input bit fe);
    pixel_t p;
    p.pixel_value = VALUE_W'(v);
    p.pixel_column = COORD_W'(c);
    p.pixel_row = COORD_W'(r);
    p.frame_end = fe;
    pixels_todo = {pixels_todo, p};
  endtask

  // Skewed toward zero, full scale and tiny values so that weights tie often
  // and big weights show up.
  function automatic int pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 0;
    if (r < 4) return 255;
    if (r < 6) return $urandom_range(1, 8);
    return $urandom_range(0, 255);
  endfunction

  // One frame in raster order inside the current band and width, with some
  // stray words and the odd early frame end mixed in.
  task automatic build_frame();
    int unsigned ew, lo_row, hi_row, span;
    int n, row, col, step_max;
    bit has_band, shaped;
    pixel_t p;
    ew = active_width();
    lo_row = band_first_reg;
    hi_row = int'(band_first_reg) + int'(band_count_reg);
    if (hi_row > ROWS) hi_row = ROWS;
    has_band = (band_count_reg != 0);
    span = has_band ? hi_row - lo_row : 1;
    row = has_band ? lo_row + $urandom_range(0, (span > 4) ? 3 : span - 1)
                   : $urandom_range(0, ROWS - 1);
    col = $urandom_range(0, (ew > 16) ? 15 : ew - 1);
    step_max = ew / 6 + 1;
    n = $urandom_range(3, 28);
    for (int k = 0; k < n; k++) begin
      shaped = ($urandom_range(0, 99) < 85);
      if (shaped) begin
        p.pixel_value = VALUE_W'(pick_value());
        p.pixel_column = COORD_W'(col);
        p.pixel_row = COORD_W'(row);
        col += $urandom_range(1, step_max);
        if (col >= ew) begin
          col -= ew;
          row++;
          if (row >= (has_band ? hi_row : ROWS)) row = has_band ? lo_row : 0;
        end
        shaped_words++;
      end else begin
        p.pixel_value = VALUE_W'($urandom);
        p.pixel_column = COORD_W'($urandom);
        p.pixel_row = COORD_W'($urandom);
      end
      p.frame_end = (k == n - 1) || (!shaped && $urandom_range(0, 15) == 0);
      pixels_todo = {pixels_todo, p};
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int pick, wcfg, fcfg, ccfg, nf, words_at_start, frames_in_mode;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: width 320, rows 160..238.
    @(negedge clk);
    queue_pixel(0, 0, 160, 0);      // zero pixel weighs nothing
    queue_pixel(255, 5, 160, 0);
    queue_pixel(1, 10, 238, 0);     // last band row, heaviest weight
    queue_pixel(2, 11, 239, 0);     // one row past the band
    queue_pixel(128, 200, 159, 0);  // one row before the band
    queue_pixel(3, 170, 200, 0);
    queue_pixel(7, 160, 200, 0);    // middle column, skipped by both scans
    queue_pixel(100, 319, 200, 0);  // last active column
    queue_pixel(1, 320, 200, 0);    // first column past the width
    queue_pixel(170, 511, 511, 1);
    queue_pixel(0, 0, 0, 1);        // nothing counted: first column of each half
    queue_pixel(51, 30, 171, 0);    // equal sums, lowest column must win
    queue_pixel(51, 20, 170, 0);
    queue_pixel(85, 300, 172, 0);
    queue_pixel(85, 200, 173, 0);
    queue_pixel(0, 0, 0, 1);
    queue_pixel(1, 50, 170, 1);     // frame-end pixel itself is counted
    settle();

    // Spare index is ignored; width 3 acts as 4; bit 9 of the first row is
    // dropped so the band is rows 500..511.
    cfg_write(CFG_SPARE, '1);
    program_band(3, 'h3F4, 1023);
    @(negedge clk);
    queue_pixel(255, 1, 511, 0);
    queue_pixel(1, 3, 500, 0);
    queue_pixel(1, 0, 499, 0);
    queue_pixel(1, 2, 505, 0);
    queue_pixel(1, 4, 505, 0);
    queue_pixel(0, 0, 0, 1);
    settle();

    // Oversized width clamps to 512, empty band.
    program_band(1023, 0, 0);
    @(negedge clk);
    queue_pixel(1, 100, 0, 0);
    queue_pixel(1, 400, 5, 0);
    queue_pixel(255, 511, 511, 1);
    settle();

    // Band runs past the last row; low rows must not wrap into it.
    program_band(512, 500, 512);
    @(negedge clk);
    queue_pixel(1, 0, 5, 0);
    queue_pixel(2, 255, 500, 0);
    queue_pixel(1, 511, 511, 0);
    queue_pixel(1, 256, 505, 0);
    queue_pixel(1, 300, 499, 1);
    settle();

    // Odd width: halves 0..1 and 3..4.
    program_band(5, 0, 512);
    @(negedge clk);
    queue_pixel(1, 4, 0, 0);
    queue_pixel(255, 3, 1, 0);
    queue_pixel(0, 2, 0, 1);
    settle();

    // Saturation: column 1 runs past the 17-bit ceiling, column 3 holds 510.
    // A wrapping column 1 would keep only 508 and hand the left peak to column 3.
    program_band(8, 0, 512);
    @(negedge clk);
    for (int i = 0; i < 516; i++) queue_pixel(1, 1, $urandom_range(0, ROWS - 1), 0);
    for (int i = 0; i < 2; i++) queue_pixel(1, 3, $urandom_range(0, ROWS - 1), 0);
    queue_pixel(255, 6, 0, 1);
    settle();

    // Random frames under random settings, three flow-control modes.
    for (int mode = 0; mode < 3; mode++) begin
      @(negedge clk);
      tx_idle_pct = (mode == 0) ? 26 : (mode == 1) ? 55 : 0;
      rx_idle_pct = (mode == 0) ? 55 : (mode == 1) ? 26 : 0;
      words_at_start = shaped_words;
      frames_in_mode = 0;
      while (shaped_words - words_at_start < RANDOM_WORDS / 3 ||
             frames_in_mode < MIN_FRAMES_PER_MODE) begin
        @(posedge clk);
        // mostly narrow images; the sweep costs the same either way
        pick = $urandom_range(0, 99);
        if (pick < 50) wcfg = $urandom_range(4, 40);
        else if (pick < 70) wcfg = $urandom_range(41, 512);
        else if (pick < 80) wcfg = $urandom_range(0, 3);
        else if (pick < 90) wcfg = $urandom_range(513, 1023);
        else wcfg = 512;
        fcfg = $urandom_range(0, 1023);
        pick = $urandom_range(0, 99);
        if (pick < 10) ccfg = 0;
        else if (pick < 20) ccfg = $urandom_range(513, 1023);
        else if (pick < 25) ccfg = 512;
        else ccfg = $urandom_range(1, 48);
        program_band(wcfg, fcfg, ccfg);
        @(negedge clk);
        nf = $urandom_range(2, 6);
        repeat (nf) build_frame();
        frames_in_mode += nf;
        settle();
      end
    end

    $display("run covered %0d pixel words (%0d from the frame builder), %0d peak words checked",
             pixels_sent, shaped_words, peaks_checked);
    $display("%0d mismatches over %0d cycles", mismatch_count, cycle_count);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
